/* rtl/nsc_pkg.sv */
// nsc_pkg: shared constants, request/result structs and the NMEA prefix table
// for the sentence capture block. No dependencies.
package nsc_pkg;

    localparam int MAX_LEN    = 128;
    localparam int SLOT_COUNT = 6;
    localparam int PREFIX_LEN = 6;

    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int BUF_AW  = $clog2(MAX_LEN);
    localparam int SLOT_AW = $clog2(SLOT_COUNT * MAX_LEN);

    typedef logic [7:0] t_byte;

    localparam t_byte CH_DOLLAR  = 8'h24;
    localparam t_byte CH_NEWLINE = 8'h0A;

    localparam logic KIND_SERIAL = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam t_byte PREFIX [SLOT_COUNT][PREFIX_LEN] = '{
        '{"$", "G", "P", "G", "G", "A"},
        '{"$", "G", "P", "G", "L", "L"},
        '{"$", "G", "P", "G", "S", "A"},
        '{"$", "G", "P", "G", "S", "V"},
        '{"$", "G", "P", "R", "M", "C"},
        '{"$", "G", "P", "V", "T", "G"}
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic [2:0] slot_select;
        logic [6:0] byte_offset;
    } t_item;

    typedef struct packed {
        logic       sentence_done;
        logic [2:0] sentence_type;
        logic       overflow_flag;
        logic [7:0] read_data;
    } t_result;

endpackage

/* rtl/nmea_sentence_capture_core.sv */
// NMEA sentence capture: microcoded framer over a capture buffer RAM and a
// slot table RAM. Depends on nsc_pkg and nsc_ram.
//
// Usage: a request is taken when start is high and busy is low. Serial bytes
// (kind 0) are framed: '$' restarts capture, newline terminates, classifies
// and copies a known sentence into its slot. Table reads (kind 1) return one
// slot byte. Every request yields exactly one result, shown on o_result for
// one cycle with o_strobe high; the receiver cannot hold it off.
// Table reads, '$', ordinary bytes and dropped bytes go from the idle step
// straight to a step that emits their result. A newline of unknown type
// runs the prefix compare over every table entry; a newline of known type
// runs the prefix compare, which reads, compares and counts each buffer
// byte in turn, then the copy moves 128 bytes through the single buffer
// read port, one byte a cycle.
// busy falls in the strobe cycle, so the next request can be taken there.
// Reset (synchronous, active low) clears position, overflow flag and slot
// valid bits; unwritten slots read as zero, so no clearing pass is needed.
// After overflow the flag stays set and bytes other than '$' drop until a '$'.
module nmea_sentence_capture_core
    import nsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int UPC_W = 4;

    // program steps
    localparam logic [UPC_W-1:0] S_IDLE   = 4'd0;
    localparam logic [UPC_W-1:0] S_READ   = 4'd1;
    localparam logic [UPC_W-1:0] S_DOLLAR = 4'd2;
    localparam logic [UPC_W-1:0] S_STORE  = 4'd3;
    localparam logic [UPC_W-1:0] S_DROP   = 4'd4;
    localparam logic [UPC_W-1:0] S_TERM   = 4'd5;
    localparam logic [UPC_W-1:0] S_MRD    = 4'd6;
    localparam logic [UPC_W-1:0] S_MCMP   = 4'd7;
    localparam logic [UPC_W-1:0] S_KCHK   = 4'd8;
    localparam logic [UPC_W-1:0] S_KLOOP  = 4'd9;
    localparam logic [UPC_W-1:0] S_TNEXT  = 4'd10;
    localparam logic [UPC_W-1:0] S_TLOOP  = 4'd11;
    localparam logic [UPC_W-1:0] S_CPINIT = 4'd12;
    localparam logic [UPC_W-1:0] S_CPLOOP = 4'd13;
    localparam logic [UPC_W-1:0] S_MATCH  = 4'd14;
    localparam logic [UPC_W-1:0] S_UNK    = 4'd15;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_EMIT_READ,
        ACT_DOLLAR,
        ACT_STORE,
        ACT_EMIT_DROP,
        ACT_TERM,
        ACT_MRD,
        ACT_KINC,
        ACT_TINC,
        ACT_CP_INIT,
        ACT_CP_WR,
        ACT_EMIT_MATCH,
        ACT_EMIT_UNK
    } t_act;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_DISPATCH,
        C_MISMATCH,
        C_KDONE,
        C_TLAST,
        C_IMORE
    } t_cond;

    typedef struct packed {
        t_act             act;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uop;

    function automatic t_uop ucode(input logic [UPC_W-1:0] a);
        t_uop u;
        u = '{act: ACT_NONE, cond: C_ALWAYS, target: S_IDLE};
        case (a)
            S_IDLE:   u = '{act: ACT_NONE,       cond: C_DISPATCH, target: S_IDLE};
            S_READ:   u = '{act: ACT_EMIT_READ,  cond: C_ALWAYS,   target: S_IDLE};
            S_DOLLAR: u = '{act: ACT_DOLLAR,     cond: C_ALWAYS,   target: S_IDLE};
            S_STORE:  u = '{act: ACT_STORE,      cond: C_ALWAYS,   target: S_IDLE};
            S_DROP:   u = '{act: ACT_EMIT_DROP,  cond: C_ALWAYS,   target: S_IDLE};
            S_TERM:   u = '{act: ACT_TERM,       cond: C_NEXT,     target: S_IDLE};
            S_MRD:    u = '{act: ACT_MRD,        cond: C_NEXT,     target: S_IDLE};
            S_MCMP:   u = '{act: ACT_KINC,       cond: C_MISMATCH, target: S_TNEXT};
            S_KCHK:   u = '{act: ACT_NONE,       cond: C_KDONE,    target: S_CPINIT};
            S_KLOOP:  u = '{act: ACT_NONE,       cond: C_ALWAYS,   target: S_MRD};
            S_TNEXT:  u = '{act: ACT_TINC,       cond: C_TLAST,    target: S_UNK};
            S_TLOOP:  u = '{act: ACT_NONE,       cond: C_ALWAYS,   target: S_MRD};
            S_CPINIT: u = '{act: ACT_CP_INIT,    cond: C_NEXT,     target: S_IDLE};
            S_CPLOOP: u = '{act: ACT_CP_WR,      cond: C_IMORE,    target: S_CPLOOP};
            S_MATCH:  u = '{act: ACT_EMIT_MATCH, cond: C_ALWAYS,   target: S_IDLE};
            S_UNK:    u = '{act: ACT_EMIT_UNK,   cond: C_ALWAYS,   target: S_IDLE};
            default:  u = '{act: ACT_NONE,       cond: C_ALWAYS,   target: S_IDLE};
        endcase
        return u;
    endfunction

    // registers
    logic [UPC_W-1:0]      r_upc,        n_upc;
    t_item                 r_item,       n_item;
    logic                  r_rd_ok,      n_rd_ok;
    logic [POS_W-1:0]      r_pos,        n_pos;
    logic                  r_ovf,        n_ovf;
    logic [SLOT_COUNT-1:0] r_slot_valid, n_slot_valid;
    logic [2:0]            r_t,          n_t;
    logic [2:0]            r_k,          n_k;
    logic [BUF_AW-1:0]     r_i,          n_i;
    logic                  r_ended,      n_ended;
    logic                  r_strobe,     n_strobe;
    t_result               r_result,     n_result;

    // datapath wires
    t_uop               uop;
    logic               take;
    logic [UPC_W-1:0]   dispatch_target;
    logic [POS_W-1:0]   adv_pos;
    logic               adv_ovf;
    t_byte              cp_byte;

    logic               buf_we;
    logic [BUF_AW-1:0]  buf_waddr;
    t_byte              buf_wdata;
    logic [BUF_AW-1:0]  buf_raddr;
    t_byte              buf_rdata;

    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    logic [SLOT_AW-1:0] slot_raddr;
    t_byte              slot_rdata;
    logic               rd_in_range;

    nsc_ram #(
        .WIDTH(8),
        .DEPTH(MAX_LEN)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (buf_we),
        .i_waddr(buf_waddr),
        .i_wdata(buf_wdata),
        .i_raddr(buf_raddr),
        .o_rdata(buf_rdata)
    );

    nsc_ram #(
        .WIDTH(8),
        .DEPTH(SLOT_COUNT * MAX_LEN)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_waddr),
        .i_wdata(cp_byte),
        .i_raddr(slot_raddr),
        .o_rdata(slot_rdata)
    );

    always_comb begin
        uop          = ucode(r_upc);
        n_item       = r_item;
        n_rd_ok      = r_rd_ok;
        n_pos        = r_pos;
        n_ovf        = r_ovf;
        n_slot_valid = r_slot_valid;
        n_t          = r_t;
        n_k          = r_k;
        n_i          = r_i;
        n_ended      = r_ended;
        n_strobe     = 1'b0;
        n_result     = r_result;

        adv_pos = r_pos + POS_W'(1);
        adv_ovf = (32'(adv_pos) >= 32'(MAX_LEN));

        cp_byte    = r_ended ? 8'h00 : buf_rdata;
        buf_we     = 1'b0;
        buf_waddr  = r_pos[BUF_AW-1:0];
        buf_wdata  = 8'h00;
        buf_raddr  = BUF_AW'(r_k);
        slot_we    = 1'b0;
        slot_waddr = SLOT_AW'(r_t) * SLOT_AW'(MAX_LEN) + SLOT_AW'(r_i);

        // table read address comes straight from the request in the idle step
        rd_in_range = (32'(i_item.slot_select) < 32'(SLOT_COUNT))
                   && (32'(i_item.byte_offset) < 32'(MAX_LEN));
        slot_raddr  = rd_in_range
                    ? SLOT_AW'(i_item.slot_select) * SLOT_AW'(MAX_LEN)
                      + SLOT_AW'(i_item.byte_offset)
                    : '0;

        if (i_item.kind == KIND_READ) begin
            dispatch_target = S_READ;
        end else if (i_item.rx_byte == CH_DOLLAR) begin
            dispatch_target = S_DOLLAR;
        end else if (32'(r_pos) < 32'(MAX_LEN)) begin
            dispatch_target = (i_item.rx_byte == CH_NEWLINE) ? S_TERM : S_STORE;
        end else begin
            dispatch_target = S_DROP;
        end

        unique case (uop.cond)
            C_NEXT:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_DISPATCH: take = 1'b1;
            C_MISMATCH: take = (buf_rdata != PREFIX[r_t][r_k]);
            C_KDONE:    take = (32'(r_k) == PREFIX_LEN);
            C_TLAST:    take = (32'(r_t) == SLOT_COUNT - 1);
            C_IMORE:    take = (32'(r_i) != MAX_LEN - 1);
            default:    take = 1'b0;
        endcase

        if (uop.cond == C_DISPATCH) begin
            n_upc = start ? dispatch_target : S_IDLE;
            if (start) begin
                n_item  = i_item;
                n_rd_ok = rd_in_range && r_slot_valid[i_item.slot_select];
            end
        end else begin
            n_upc = take ? uop.target : r_upc + UPC_W'(1);
        end

        unique case (uop.act)
            ACT_NONE: begin
            end
            ACT_EMIT_READ: begin
                n_strobe = 1'b1;
                n_result = '{sentence_done: 1'b0, sentence_type: 3'd0,
                             overflow_flag: r_ovf,
                             read_data: r_rd_ok ? slot_rdata : 8'h00};
            end
            ACT_DOLLAR: begin
                buf_we    = 1'b1;
                buf_waddr = '0;
                buf_wdata = CH_DOLLAR;
                n_pos     = POS_W'(1);
                n_strobe  = 1'b1;
                n_result  = '{sentence_done: 1'b0, sentence_type: 3'd0,
                              overflow_flag: r_ovf, read_data: 8'h00};
            end
            ACT_STORE: begin
                buf_we    = 1'b1;
                buf_wdata = r_item.rx_byte;
                n_pos     = adv_ovf ? POS_W'(MAX_LEN) : adv_pos;
                n_ovf     = r_ovf | adv_ovf;
                n_strobe  = 1'b1;
                n_result  = '{sentence_done: 1'b0, sentence_type: 3'd0,
                              overflow_flag: r_ovf | adv_ovf, read_data: 8'h00};
            end
            ACT_EMIT_DROP: begin
                n_strobe = 1'b1;
                n_result = '{sentence_done: 1'b0, sentence_type: 3'd0,
                             overflow_flag: r_ovf, read_data: 8'h00};
            end
            ACT_TERM: begin
                // terminator goes in, position still advances
                buf_we    = 1'b1;
                buf_wdata = 8'h00;
                n_pos     = adv_ovf ? POS_W'(MAX_LEN) : adv_pos;
                n_ovf     = r_ovf | adv_ovf;
                n_t       = '0;
                n_k       = '0;
            end
            ACT_MRD: begin
                buf_raddr = BUF_AW'(r_k);
            end
            ACT_KINC: begin
                n_k = r_k + 3'd1;
            end
            ACT_TINC: begin
                n_t = r_t + 3'd1;
                n_k = '0;
            end
            ACT_CP_INIT: begin
                buf_raddr = '0;
                n_i       = '0;
                n_ended   = 1'b0;
            end
            ACT_CP_WR: begin
                // byte i arrives now; fetch i+1 for the next step
                slot_we   = 1'b1;
                buf_raddr = r_i + BUF_AW'(1);
                n_i       = r_i + BUF_AW'(1);
                n_ended   = r_ended | (buf_rdata == 8'h00);
            end
            ACT_EMIT_MATCH: begin
                n_slot_valid[r_t] = 1'b1;
                n_strobe = 1'b1;
                n_result = '{sentence_done: 1'b1, sentence_type: r_t + 3'd1,
                             overflow_flag: r_ovf, read_data: 8'h00};
            end
            ACT_EMIT_UNK: begin
                n_strobe = 1'b1;
                n_result = '{sentence_done: 1'b1, sentence_type: 3'd0,
                             overflow_flag: r_ovf, read_data: 8'h00};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc        <= S_IDLE;
            r_pos        <= '0;
            r_ovf        <= 1'b0;
            r_slot_valid <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_upc        <= n_upc;
            r_pos        <= n_pos;
            r_ovf        <= n_ovf;
            r_slot_valid <= n_slot_valid;
            r_strobe     <= n_strobe;
        end
        r_item   <= n_item;
        r_rd_ok  <= n_rd_ok;
        r_t      <= n_t;
        r_k      <= n_k;
        r_i      <= n_i;
        r_ended  <= n_ended;
        r_result <= n_result;
    end

    assign busy     = (r_upc != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

/* rtl/nsc_ram.sv */
// nsc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module nsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/nsc_checker.sv */
// nsc_checker: port-level assertions for nmea_sentence_capture_core, bound
// into every instance of that core. Depends on nsc_pkg.
module nsc_checker
    import nsc_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input t_item   i_item,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    // a result only shows once the sequencer is back in its idle step
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // an accepted request always takes the sequencer out of its idle step
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back result strobes");

    // table reads answer with a result strobe and never report a sentence
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.kind == KIND_READ)
            |=> ##1 (o_strobe && !o_result.sentence_done))
        else $error("table read result missing or malformed");

    a_done_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.sentence_done) |-> (o_result.read_data == 8'h00))
        else $error("sentence result carries read data");

endmodule

bind nmea_sentence_capture_core nsc_checker u_nsc_checker (.*);

/* tb/tb_nmea_sentence_capture_core.sv */
// Testbench for nmea_sentence_capture_core: sentence framing, classification,
// slot copy, table reads and the sticky overflow. Self-checking against its
// own framer model. Depends on nsc_pkg and the core RTL.
module tb_nmea_sentence_capture_core;
    import nsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        t_item req;
        bit    hold;    // wait until every due result has come before issuing
    } t_queued_req;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_item   i_item = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    nmea_sentence_capture_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // framer model state
    bit [7:0] line_buf [MAX_LEN];
    bit [7:0] slot_mem [SLOT_COUNT][MAX_LEN];
    int       line_pos = 0;
    bit       overrun = 1'b0;
    string    sentence_tags [SLOT_COUNT] = '{"GGA", "GLL", "GSA", "GSV", "RMC", "VTG"};

    t_queued_req queued_requests [$];
    t_result     due_results [$];
    bit          hold_next = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          gap_left = 0;
    int          burst_left = 0;
    bit          holding;
    bit          launch;
    t_queued_req nxt;
    t_result     want;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result frame_and_classify(t_item it);
        t_result r;
        string   tag;
        int      t;
        int      k;
        int      i;
        int      found;
        bit      ended;
        bit [7:0] c;
        r = '0;
        if (it.kind == KIND_READ) begin
            if (it.slot_select < SLOT_COUNT)
                r.read_data = slot_mem[it.slot_select][it.byte_offset];
        end else if (it.rx_byte == CH_DOLLAR) begin
            line_buf[0] = it.rx_byte;
            line_pos = 1;
        end else if (line_pos < MAX_LEN) begin
            if (it.rx_byte == CH_NEWLINE) begin
                line_buf[line_pos] = 8'h00;
                r.sentence_done = 1'b1;
                found = -1;
                for (t = 0; t < SLOT_COUNT; t++) begin
                    tag = {"$GP", sentence_tags[t]};
                    if (found < 0) begin
                        found = t;
                        for (k = 0; k < 6; k++)
                            if (line_buf[k] != tag[k]) found = -1;
                    end
                end
                if (found >= 0) begin
                    r.sentence_type = 3'(found + 1);
                    ended = 1'b0;
                    // strncpy-style: copy up to the first zero, pad the rest
                    for (i = 0; i < MAX_LEN; i++) begin
                        c = ended ? 8'h00 : line_buf[i];
                        if (c == 8'h00) ended = 1'b1;
                        slot_mem[found][i] = c;
                    end
                end
            end else begin
                line_buf[line_pos] = it.rx_byte;
            end
            line_pos++;
            if (line_pos >= MAX_LEN) begin
                line_pos = MAX_LEN;
                overrun = 1'b1;
            end
        end
        r.overflow_flag = overrun;
        return r;
    endfunction

    task automatic queue_byte(t_byte b);
        t_queued_req q;
        q.req.kind = KIND_SERIAL;
        q.req.rx_byte = b;
        q.req.slot_select = 3'($urandom_range(0, 7));
        q.req.byte_offset = 7'($urandom_range(0, 127));
        q.hold = hold_next;
        hold_next = 1'b0;
        queued_requests.push_back(q);
    endtask

    task automatic queue_read(int sel, int off);
        t_queued_req q;
        q.req.kind = KIND_READ;
        q.req.rx_byte = 8'($urandom_range(0, 255));
        q.req.slot_select = 3'(sel);
        q.req.byte_offset = 7'(off);
        q.hold = hold_next;
        hold_next = 1'b0;
        queued_requests.push_back(q);
    endtask

    task automatic queue_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    function automatic t_byte body_char();
        t_byte c;
        int    pick;
        pick = $urandom_range(0, 39);
        if (pick == 0) return 8'h00;
        do begin
            if (pick == 1) c = 8'($urandom_range(0, 255));
            else c = 8'($urandom_range(8'h20, 8'h7E));
        end while (c == CH_DOLLAR || c == CH_NEWLINE);
        return c;
    endfunction

    // One sentence with random content; some prefixes are unknown, corrupted or cut short.
    // Bodies stay short enough that the position never reaches the overflow point.
    task automatic queue_sentence();
        string head;
        int    kind_pick;
        int    body_len;
        int    i;
        kind_pick = $urandom_range(0, 8);
        head = {"$GP", sentence_tags[$urandom_range(0, SLOT_COUNT - 1)]};
        if (kind_pick == 6) begin
            for (i = 3; i < 6; i++) head[i] = 8'($urandom_range("A", "Z"));
        end else if (kind_pick == 7) begin
            head[$urandom_range(1, 5)] = body_char();
        end else if (kind_pick == 8) begin
            head = head.substr(0, $urandom_range(0, 4));
        end
        queue_text(head);
        if (kind_pick == 8) begin
            queue_byte(CH_NEWLINE);
            return;
        end
        body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 100)
                                                : $urandom_range(0, 20);
        for (i = 0; i < body_len; i++) queue_byte(body_char());
        if ($urandom_range(0, 11) != 0) queue_byte(CH_NEWLINE);
    endtask

    // Request source
    initial begin
        int i;
        int n;
        int pick;

        // directed: empty table extremes, bad slots
        queue_read(0, 0);
        queue_read(SLOT_COUNT - 1, MAX_LEN - 1);
        queue_read(6, 5);
        queue_read(7, 127);
        queue_text("$GPGGA\n");
        queue_read(0, 5);
        queue_read(0, 6);
        // short sentence: terminator inside the prefix
        queue_text("$GP\n");
        // zero byte received: the copy stops there
        queue_text("$GPRMC");
        queue_byte(8'h00);
        queue_text("A\n");
        queue_read(4, 7);
        // newline right after newline re-classifies the same buffer
        queue_byte(CH_NEWLINE);

        // random traffic
        hold_next = 1'b1;
        while (queued_requests.size() < 430) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                queue_sentence();
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                    queue_read($urandom_range(0, 7), $urandom_range(0, 1) ?
                               $urandom_range(0, 15) : $urandom_range(0, 127));
            end else if (pick < 8) begin
                queue_read($urandom_range(0, 7), $urandom_range(0, 127));
            end else begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)));
            end
        end

        // longest sentence that fits: terminator lands at MAX_LEN - 2
        queue_text("$GPGSV");
        for (i = 0; i < MAX_LEN - 8; i++) queue_byte(body_char());
        queue_byte(CH_NEWLINE);
        queue_read(3, MAX_LEN - 3);
        queue_read(3, MAX_LEN - 2);
        queue_read(3, MAX_LEN - 1);
        queue_read(3, 0);
        // next byte pushes the position to MAX_LEN: overflow, then drop
        hold_next = 1'b1;
        queue_byte("X");
        queue_byte(CH_NEWLINE);
        for (i = 0; i < 6; i++) queue_byte(body_char());
        queue_byte(CH_NEWLINE);
        queue_text("$GPVTG,1.5\n");
        queue_read(5, 0);
        queue_read(5, 9);
        queue_read(5, 10);
        queue_text("$GPGLL,x\n");
        queue_read(1, 7);
    end

    // Reset and end of run
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (queued_requests.size() != 0 || start || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        // every request must have been answered by now
        if (mismatch_count == 0 && due_results.size() == 0 &&
            queued_requests.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Driver: prediction is taken at the accept edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            launch = 1'b0;
            holding = start && busy;
            if (start && !busy) begin
                due_results.push_back(frame_and_classify(i_item));
                if (burst_left > 0) begin
                    burst_left--;
                    gap_left = 0;
                end else begin
                    gap_left = $urandom_range(0, 11);
                    if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(8, 40);
                end
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (queued_requests.size() != 0 &&
                             !(queued_requests[0].hold && due_results.size() != 0)) begin
                    nxt = queued_requests.pop_front();
                    i_item <= nxt.req;
                    launch = 1'b1;
                end
            end
            start <= holding || launch;
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (due_results.size() == 0) begin
                $error("result with no request outstanding: %h", o_result);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                if (o_result.sentence_done !== want.sentence_done) begin
                    $error("sentence_done: expected %0d, got %0d",
                           want.sentence_done, o_result.sentence_done);
                    mismatch_count++;
                end
                if (o_result.sentence_type !== want.sentence_type) begin
                    $error("sentence_type: expected %0d, got %0d",
                           want.sentence_type, o_result.sentence_type);
                    mismatch_count++;
                end
                if (o_result.overflow_flag !== want.overflow_flag) begin
                    $error("overflow_flag: expected %0d, got %0d",
                           want.overflow_flag, o_result.overflow_flag);
                    mismatch_count++;
                end
                if (o_result.read_data !== want.read_data) begin
                    $error("read_data: expected 0x%02h, got 0x%02h",
                           want.read_data, o_result.read_data);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
